// ===== hw/rtl/cfs_pkg.sv =====
// Shared types, character codes and byte classifiers for the command frame sanitizer.
// Used by cfs_parse and command_frame_sanitizer; depends on nothing else.
`default_nettype none

package cfs_pkg;

  localparam int unsigned MaxFrameBytes = 256;

  localparam logic [7:0] AddrMax = 8'd254;
  localparam logic [6:0] IdxMax  = 7'd63;
  localparam logic [6:0] IdxOver = 7'h7F;

  localparam logic [7:0] ChM      = 8'h6D;
  localparam logic [7:0] ChX      = 8'h58;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChPrintLo = 8'h20;
  localparam logic [7:0] ChPrintHi = 8'h7E;
  localparam logic [7:0] ChHome   = 8'h68;
  localparam logic [7:0] ChLc     = 8'h63;
  localparam logic [7:0] ChLd     = 8'h64;
  localparam logic [7:0] ChLe     = 8'h65;
  localparam logic [7:0] ChUr     = 8'h52;
  localparam logic [7:0] ChUf     = 8'h46;
  localparam logic [7:0] ChVer    = 8'h76;
  localparam logic [7:0] ChUa     = 8'h41;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChLo     = 8'h6F;
  localparam logic [7:0] ChLt     = 8'h74;
  localparam logic [7:0] ChLs     = 8'h73;
  localparam logic [7:0] ChLg     = 8'h67;
  localparam logic [7:0] ChLa     = 8'h61;
  localparam logic [7:0] ChLi     = 8'h69;
  localparam logic [7:0] ChLw     = 8'h77;

  // Register index of the configuration port.
  localparam logic RegQuiet = 1'b0;

  typedef enum logic [1:0] {
    ST_SEND  = 2'd0,
    ST_TERM  = 2'd1,
    ST_LONG  = 2'd2,
    ST_QUIET = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_CHAR  = 2'd1,
    ACT_INDEX = 2'd2,
    ACT_HOME  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CL_FIXED,
    CL_QUERY,
    CL_DASH,
    CL_DIGITS,
    CL_WRITE,
    CL_OTHER
  } cmd_class_e;

  typedef enum logic [13:0] {
    PH_M       = 14'b00000000000001,
    PH_SEL     = 14'b00000000000010,
    PH_ADDR    = 14'b00000000000100,
    PH_NOCMD   = 14'b00000000001000,
    PH_CMDWAIT = 14'b00000000010000,
    PH_DONE    = 14'b00000000100000,
    PH_WHOLE   = 14'b00000001000000,
    PH_DASH    = 14'b00000010000000,
    PH_DIG0    = 14'b00000100000000,
    PH_DIGRUN  = 14'b00001000000000,
    PH_W0      = 14'b00010000000000,
    PH_W1      = 14'b00100000000000,
    PH_W2      = 14'b01000000000000,
    PH_W3      = 14'b10000000000000
  } phase_e;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return (c == ChLf) || (c == ChCr);
  endfunction

  function automatic cmd_class_e cmd_class(input logic [7:0] c);
    cmd_class_e cl;
    case (c)
      ChHome, ChLc, ChLd, ChLe, ChUr, ChUf:          cl = CL_FIXED;
      ChVer, ChUa:                                   cl = CL_QUERY;
      ChMinus:                                       cl = CL_DASH;
      ChPlus, ChLo, ChLt, ChLs, ChLg, ChLa, ChLi:    cl = CL_DIGITS;
      ChLw:                                          cl = CL_WRITE;
      default:                                       cl = CL_OTHER;
    endcase
    return cl;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/command_frame_sanitizer.sv =====
// Command frame sanitizer: bytes in on a stream slave, one verdict per frame out on a master.
// Depends on cfs_pkg and cfs_parse.
//
// Usage: frame bytes arrive on s_axis (tdata = byte, tlast = last byte of the frame,
// tuser = raw mode, taken from the first byte). Each byte is registered and parsed in
// the following cycle; the parser is a small state update, so one byte is taken every
// cycle unless a last byte waits. Only the last byte of a frame yields a request on m_axis,
// carrying the verdict (status, send length, newline, trim flag, command, address,
// broadcast, motion and tracking fields). The last byte passes the input register
// and the parse step into the verdict register, which drives m_axis_tvalid_o.
// Throughput is one byte per cycle, frames back to back, while the receiver takes
// each verdict as it comes.
// When the receiver stalls with a verdict waiting, bytes that are not a frame's last
// keep flowing; a last byte waits in the input register and stalls s_axis behind it.
// Reset clears the frame in flight and the quiet-time register; the block is ready
// straight out of reset. The APB port holds one register, decoded on paddr[2] == 0
// (addresses 0 to 3): bit 0 enables quiet time, which suppresses display motion
// frames. Write it only while no frame is in flight.
`default_nettype none

module command_frame_sanitizer import cfs_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytes,
  localparam int unsigned LenW  = $clog2(MAX_FRAME_BYTES + 1),
  localparam int unsigned VerdW = LenW + 39,
  localparam int unsigned OutW  = ((VerdW + 7) / 8) * 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // frame_byte
  input  wire logic [7:0]      s_axis_tdata_i,
  input  wire logic            s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  wire logic            s_axis_tlast_i,
  // raw_mode
  input  wire logic            s_axis_tuser_i,
  // status, send_length, append_newline, was_trimmed, command_char, module_address,
  // is_broadcast, is_display_motion, tracking_action, shown_char, flap_index
  output logic [OutW-1:0]      m_axis_tdata_o,
  output logic                 m_axis_tvalid_o,
  input  wire logic            m_axis_tready_i,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic             in_vld_q, in_last_q, in_raw_q;
  logic [7:0]       in_byte_q;
  logic             out_vld_q, out_free, step;
  logic [VerdW-1:0] out_q, verdict;
  logic             quiet_q;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign step            = in_vld_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
      in_raw_q  <= s_axis_tuser_i;
    end
  end

  cfs_parse #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .raw_i    (in_raw_q),
    .quiet_i  (quiet_q),
    .verdict_o(verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= step && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      out_q <= verdict;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OutW'(out_q);

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegQuiet) ? {31'd0, quiet_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegQuiet) begin
      quiet_q <= pwdata[0];
    end
  end

  a_stall_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_vld_q && in_last_q && out_vld_q)
    else $error("input stalled without a waiting final byte");

  a_verdict_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_last_q |=> m_axis_tvalid_o)
    else $error("final byte gave no verdict request");

  a_verdict_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(out_q))
    else $error("waiting verdict changed or dropped");

endmodule

`default_nettype wire

// ===== hw/rtl/cfs_parse.sv =====
// Per-byte frame parser: holds the parse state of the frame in flight and forms the verdict.
// Depends on cfs_pkg.
`default_nettype none

module cfs_parse import cfs_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytes,
  localparam int unsigned PosW  = $clog2(MAX_FRAME_BYTES + 2),
  localparam int unsigned LenW  = $clog2(MAX_FRAME_BYTES + 1),
  localparam int unsigned VerdW = LenW + 39
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic             last_i,
  input  wire logic             raw_i,
  input  wire logic             quiet_i,
  output logic [VerdW-1:0]      verdict_o
);

  // Declared high field first so that status lands in the lowest bits.
  typedef struct packed {
    logic [6:0]      findex;
    logic [7:0]      shown;
    action_e         action;
    logic            motion;
    logic            bc;
    logic [7:0]      addr;
    logic [7:0]      cmd;
    logic            trim;
    logic            nl;
    logic [LenW-1:0] send_len;
    status_e         status;
  } verdict_t;

  localparam logic [PosW-1:0] PosMax = PosW'(MAX_FRAME_BYTES);

  phase_e          phase_q, phase_nx;
  logic [PosW-1:0] pos_q, pos_nx, end_q, end_nx;
  logic [7:0]      addr_q, addr_nx, cmd_q, cmd_nx, pay_q, pay_nx;
  logic [6:0]      idx_q, idx_nx;
  logic            bc_q, bc_nx, cmd_vld_q, cmd_vld_nx, has_pay_q, has_pay_nx;
  logic            raw_q, raw_nx, content_q;
  verdict_t        snap_q, cur_v, res_v;

  logic            dig, start_cmd, home, motion;
  logic [3:0]      dval;
  logic [11:0]     addr_step;
  logic [9:0]      idx_step;
  logic [7:0]      cmd_eff;
  logic [PosW-1:0] cut_len;

  assign dig       = is_digit(byte_i);
  assign dval      = byte_i[3:0];
  assign addr_step = {1'b0, addr_q, 3'b000} + {3'b000, addr_q, 1'b0} + {8'd0, dval};
  assign idx_step  = {idx_q, 3'b000} + {2'b00, idx_q, 1'b0} + {6'd0, dval};

  always_comb begin
    phase_nx   = phase_q;
    end_nx     = end_q;
    addr_nx    = addr_q;
    cmd_nx     = cmd_q;
    pay_nx     = pay_q;
    idx_nx     = idx_q;
    bc_nx      = bc_q;
    cmd_vld_nx = cmd_vld_q;
    has_pay_nx = has_pay_q;
    start_cmd  = 1'b0;
    pos_nx     = (pos_q > PosMax) ? pos_q : pos_q + 1'b1;
    raw_nx     = (pos_q == '0) ? raw_i : raw_q;

    if (cmd_vld_q && !has_pay_q) begin
      pay_nx     = byte_i;
      has_pay_nx = 1'b1;
    end

    case (phase_q)
      PH_M: begin
        phase_nx = (byte_i == ChM) ? PH_SEL : PH_NOCMD;
      end
      PH_SEL: begin
        if (byte_i == ChStar) begin
          phase_nx = PH_CMDWAIT;
          bc_nx    = 1'b1;
        end else if (dig && byte_i != ChX) begin
          phase_nx = PH_ADDR;
          addr_nx  = {4'd0, dval};
        end else begin
          phase_nx = PH_NOCMD;
        end
      end
      PH_ADDR: begin
        if (dig) begin
          addr_nx = (addr_step > 12'd255) ? 8'hFF : addr_step[7:0];
        end else if (addr_q > AddrMax) begin
          phase_nx = PH_NOCMD;
        end else begin
          start_cmd = 1'b1;
        end
      end
      PH_CMDWAIT: begin
        start_cmd = 1'b1;
      end
      PH_DASH: begin
        phase_nx = PH_DONE;
        end_nx   = pos_q + 1'b1;
      end
      PH_DIG0: begin
        if (dig) begin
          phase_nx = PH_DIGRUN;
          idx_nx   = {3'd0, dval};
        end else begin
          phase_nx = PH_WHOLE;
        end
      end
      PH_DIGRUN: begin
        if (dig) begin
          // Once the index is past its range it stays at the out-of-range mark.
          if (idx_q <= IdxMax) begin
            idx_nx = (idx_step > 10'd63) ? IdxOver : idx_step[6:0];
          end
        end else begin
          phase_nx = PH_DONE;
          end_nx   = pos_q;
        end
      end
      PH_W0: begin
        phase_nx = dig ? PH_W1 : PH_WHOLE;
      end
      PH_W1: begin
        if (byte_i == ChColon) begin
          phase_nx = PH_W2;
        end else if (!dig) begin
          phase_nx = PH_WHOLE;
        end
      end
      PH_W2: begin
        phase_nx = dig ? PH_W3 : PH_WHOLE;
      end
      PH_W3: begin
        if (!dig) begin
          phase_nx = PH_DONE;
          end_nx   = pos_q;
        end
      end
      PH_DONE, PH_WHOLE, PH_NOCMD: begin
        phase_nx = phase_q;
      end
      default: begin
        phase_nx = PH_NOCMD;
      end
    endcase

    if (start_cmd) begin
      cmd_nx     = byte_i;
      cmd_vld_nx = 1'b1;
      case (cmd_class(byte_i))
        CL_FIXED: begin
          phase_nx = PH_DONE;
          end_nx   = pos_q + 1'b1;
        end
        CL_QUERY: begin
          phase_nx = bc_q ? PH_WHOLE : PH_DONE;
          end_nx   = pos_q + 1'b1;
        end
        CL_DASH:   phase_nx = PH_DASH;
        CL_DIGITS: phase_nx = PH_DIG0;
        CL_WRITE:  phase_nx = PH_W0;
        default:   phase_nx = PH_WHOLE;
      endcase
    end
  end

  // Verdict for the frame as if it ended with the current byte.
  always_comb begin
    cmd_eff = cmd_vld_nx ? cmd_nx : 8'd0;
    cut_len = (phase_nx == PH_DONE) ? end_nx : pos_nx;
    home    = (cmd_eff == ChHome) && (!raw_nx || !has_pay_nx || is_term(pay_nx));
    motion  = (cmd_eff == ChMinus) || (cmd_eff == ChPlus) || home;

    cur_v        = '0;
    cur_v.cmd    = cmd_eff;
    cur_v.addr   = (cmd_eff != 8'd0 && !bc_nx) ? addr_nx : 8'd0;
    cur_v.bc     = (cmd_eff != 8'd0) && bc_nx;
    cur_v.motion = motion;
    cur_v.trim   = !raw_nx && (cut_len < pos_nx);
    cur_v.status = ST_SEND;
    cur_v.action = ACT_NONE;

    if (quiet_i && motion) begin
      cur_v.status = ST_QUIET;
    end else begin
      cur_v.send_len = raw_nx ? LenW'(pos_nx) : LenW'(cut_len);
      cur_v.nl       = !raw_nx && !((cmd_eff == ChVer) && !bc_nx);
      if (cmd_eff == ChMinus) begin
        if (has_pay_nx && pay_nx >= ChPrintLo && pay_nx <= ChPrintHi) begin
          cur_v.action = ACT_CHAR;
          cur_v.shown  = pay_nx;
        end
      end else if (cmd_eff == ChPlus) begin
        if (has_pay_nx && is_digit(pay_nx)) begin
          cur_v.action = ACT_INDEX;
          cur_v.findex = idx_nx;
        end
      end else if (home) begin
        cur_v.action = ACT_HOME;
      end
    end

    res_v = '0;
    if (pos_q >= PosMax) begin
      res_v.status = ST_LONG;
    end else if (raw_nx || !is_term(byte_i)) begin
      res_v = cur_v;
    end else if (content_q) begin
      // Trailing terminators: the verdict stands as of the last content byte.
      res_v = snap_q;
    end else begin
      res_v.status = ST_TERM;
    end
  end

  assign verdict_o = res_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_M;
      pos_q     <= '0;
      end_q     <= '0;
      addr_q    <= '0;
      cmd_q     <= '0;
      pay_q     <= '0;
      idx_q     <= '0;
      bc_q      <= 1'b0;
      cmd_vld_q <= 1'b0;
      has_pay_q <= 1'b0;
      raw_q     <= 1'b0;
      content_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q   <= PH_M;
        pos_q     <= '0;
        end_q     <= '0;
        addr_q    <= '0;
        cmd_q     <= '0;
        pay_q     <= '0;
        idx_q     <= '0;
        bc_q      <= 1'b0;
        cmd_vld_q <= 1'b0;
        has_pay_q <= 1'b0;
        raw_q     <= 1'b0;
        content_q <= 1'b0;
      end else begin
        phase_q   <= phase_nx;
        pos_q     <= pos_nx;
        end_q     <= end_nx;
        addr_q    <= addr_nx;
        cmd_q     <= cmd_nx;
        pay_q     <= pay_nx;
        idx_q     <= idx_nx;
        bc_q      <= bc_nx;
        cmd_vld_q <= cmd_vld_nx;
        has_pay_q <= has_pay_nx;
        raw_q     <= raw_nx;
        if (!is_term(byte_i)) begin
          content_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && !is_term(byte_i)) begin
      snap_q <= cur_v;
    end
  end

  // The byte count saturates on overlong frames, so the bound holds only within the buffer.
  a_done_end_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE && pos_q <= PosMax |-> end_q <= pos_q)
    else $error("command end lies beyond the bytes seen");

  a_payload_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_pay_q |-> cmd_vld_q)
    else $error("payload captured without a command byte");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> pos_q == '0 && !content_q && phase_q == PH_M)
    else $error("frame state not cleared after the last byte");

endmodule

`default_nettype wire
